/* rtl/core/stsch_pkg.sv */
// Shared types, codes and helpers of the periodic task slot scheduler.
`default_nettype none

package stsch_pkg;

    // Table geometry.
    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_RES   = 8;
    localparam int NREP_W    = $clog2(MAX_RES + 1);

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int WORD_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    // Operation codes carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REG   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

    typedef logic [IDX_W-1:0]  slot_idx_t;
    typedef logic [WORD_W-1:0] word_t;

    // One result item.
    typedef struct packed {
        logic              fired;
        word_t             handle;
        logic [SLOT_W-1:0] slot_index;
        logic [STAT_W-1:0] status;
        logic              last;
    } result_t;

    // Per-slot answer of the shared slot unit.
    typedef struct packed {
        logic  hit;
        word_t new_count;
    } alu_res_t;

    // Reported slot number: the low bits of the table index.
    function automatic logic [SLOT_W-1:0] to_slot_index(input slot_idx_t idx);
        logic [5:0] wide;
        wide = 6'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/stsch_slot_alu.sv */
// Shared slot unit: saturating add, period compare and subtract, handle match or empty-slot match.
`default_nettype none

module stsch_slot_alu (
    input  wire logic [1:0]          func,
    input  wire stsch_pkg::word_t    elapsed,
    input  wire stsch_pkg::word_t    cmd_handle,
    input  wire stsch_pkg::word_t    slot_handle,
    input  wire stsch_pkg::word_t    slot_period,
    input  wire stsch_pkg::word_t    slot_count,
    output stsch_pkg::alu_res_t      res
);
    import stsch_pkg::*;

    logic [WORD_W:0] sum;
    word_t           sat;
    logic            active;
    logic            over;

    // Counter advance with saturation at the full word.
    always_comb begin
        sum    = {1'b0, slot_count} + {1'b0, elapsed};
        sat    = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
        active = (slot_period != '0);
        over   = active && (sat > slot_period);
    end

    // Per-operation answer for the slot under visit.
    always_comb begin
        res.new_count = slot_count;
        res.hit       = 1'b0;
        case (func)
            FUNC_TICK: begin
                res.hit = over;
                if (active) begin
                    res.new_count = over ? (sat - slot_period) : sat;
                end
            end
            FUNC_REG: begin
                res.hit = (slot_handle == '0);
            end
            default: begin
                res.hit = (slot_handle == cmd_handle);
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/stsch_out_reg.sv */
// Output register of the result channel.
`default_nettype none

module stsch_out_reg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire stsch_pkg::result_t         push_data,
    output logic                            free,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [stsch_pkg::M_DATA_W-1:0]  m_tdata,  // handle, slot_index, status, zero fill
    output logic                            m_tuser,  // fired
    output logic                            m_tlast
);
    import stsch_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // The register may take a new result when empty or being drained.
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && push) begin
            data_reg <= push_data;
        end
    end

    // Port packing.
    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.fired;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {3'b000, data_reg.status, data_reg.slot_index, data_reg.handle};

endmodule

`default_nettype wire

/* rtl/core/periodic_task_slot_scheduler.sv */
// Top level of the periodic task slot scheduler: sequencer and slot tables.
//
// Input transfers carry the operation on s_tuser (0 tick, 1 register, 2 stop,
// 3 start) and elapsed count, task handle and period on s_tdata. Result
// transfers carry the fired flag on m_tuser, handle, slot and status on
// m_tdata, and m_tlast on the final result of an input item.
// One input item is taken at a time; s_tready is high only while the
// sequencer is idle. The sequencer walks the slot table one slot per cycle,
// except while a stall holds it, through a single shared slot unit: a tick
// visits every slot and then flushes, a command visits slots up to the first
// matching or empty one and then flushes, a command with a zero handle goes
// straight to the flush, and a tick with zero elapsed count finishes right
// away.
// Fired slots are held one deep so the last one can be marked; each further
// fire must hand the held result to the output register, and the walk waits
// while the receiver stalls with the output register full.
// Results leave through the output register, so the result channel is registered.
// Synchronous reset empties every slot and stops all tasks.
`default_nettype none

module periodic_task_slot_scheduler (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [stsch_pkg::S_DATA_W-1:0] s_tdata,  // elapsed_ticks, task_handle, period
    input  wire logic [stsch_pkg::FUNC_W-1:0]   s_tuser,  // func
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [stsch_pkg::M_DATA_W-1:0]  m_tdata,  // fired_handle, slot_index, status, zero fill
    output logic                            m_tuser,  // fired
    output logic                            m_tlast
);
    import stsch_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    word_t               elapsed_reg, elapsed_next;
    word_t               handle_reg, handle_next;
    word_t               period_reg, period_next;
    slot_idx_t           idx_reg, idx_next;
    logic [NREP_W-1:0]   nrep_reg, nrep_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;

    word_t               hdl_tab [NUM_SLOTS];
    word_t               per_tab [NUM_SLOTS];
    word_t               cnt_tab [NUM_SLOTS];

    logic                cnt_we, per_we, hdl_we;
    word_t               per_wdata;

    word_t               in_elapsed, in_handle, in_period;
    alu_res_t            alu;
    logic                last_slot, report, stall;
    logic                push, out_free;
    result_t             push_data;

    assign in_elapsed = s_tdata[15:0];
    assign in_handle  = s_tdata[31:16];
    assign in_period  = s_tdata[47:32];
    assign s_tready   = (state_reg == ST_IDLE);

    // Shared unit sees the slot under visit.
    stsch_slot_alu u_alu (
        .func        (func_reg),
        .elapsed     (elapsed_reg),
        .cmd_handle  (handle_reg),
        .slot_handle (hdl_tab[idx_reg]),
        .slot_period (per_tab[idx_reg]),
        .slot_count  (cnt_tab[idx_reg]),
        .res         (alu)
    );

    assign last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign report    = alu.hit && (nrep_reg < NREP_W'(MAX_RES));
    assign stall     = report && pend_valid_reg && !out_free;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        elapsed_next    = elapsed_reg;
        handle_next     = handle_reg;
        period_next     = period_reg;
        idx_next        = idx_reg;
        nrep_next       = nrep_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cnt_we          = 1'b0;
        per_we          = 1'b0;
        hdl_we          = 1'b0;
        per_wdata       = period_reg;
        push            = 1'b0;
        push_data       = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next       = s_tuser;
                    elapsed_next    = in_elapsed;
                    handle_next     = in_handle;
                    period_next     = in_period;
                    idx_next        = '0;
                    nrep_next       = '0;
                    pend_valid_next = 1'b0;
                    if (s_tuser == FUNC_TICK) begin
                        if (in_elapsed != '0) begin
                            state_next = ST_WALK;
                        end
                    end else if (in_handle == '0) begin
                        pend_next       = '{fired: 1'b0, handle: in_handle, slot_index: '0,
                                            status: STAT_NOTFOUND, last: 1'b1};
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (func_reg == FUNC_TICK) begin
                    // Advance one slot; a new fire first hands over the held one.
                    if (!stall) begin
                        cnt_we = 1'b1;
                        if (report) begin
                            push            = pend_valid_reg;
                            push_data       = pend_reg;
                            pend_next       = '{fired: 1'b1, handle: hdl_tab[idx_reg],
                                                slot_index: to_slot_index(idx_reg),
                                                status: STAT_OK, last: 1'b0};
                            pend_valid_next = 1'b1;
                            nrep_next       = nrep_reg + 1'b1;
                        end
                        if (last_slot) begin
                            state_next = ST_FLUSH;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end else begin
                    // Command search for the first matching or empty slot.
                    if (alu.hit) begin
                        per_we          = 1'b1;
                        hdl_we          = (func_reg == FUNC_REG);
                        per_wdata       = (func_reg == FUNC_STOP) ? '0 : period_reg;
                        pend_next       = '{fired: 1'b0, handle: handle_reg,
                                            slot_index: to_slot_index(idx_reg),
                                            status: STAT_OK, last: 1'b1};
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end else if (last_slot) begin
                        pend_next       = '{fired: 1'b0, handle: handle_reg, slot_index: '0,
                                            status: (func_reg == FUNC_REG) ? STAT_FULL
                                                                           : STAT_NOTFOUND,
                                            last: 1'b1};
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                // The held result is the final one of this item.
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_data       = pend_reg;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            nrep_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
            nrep_reg       <= nrep_next;
        end
    end

    // Item and held-result payload.
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        elapsed_reg <= elapsed_next;
        handle_reg  <= handle_next;
        period_reg  <= period_next;
        pend_reg    <= pend_next;
    end

    // Slot tables, written at the visited slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                hdl_tab[i] <= '0;
                per_tab[i] <= '0;
                cnt_tab[i] <= '0;
            end
        end else begin
            if (cnt_we) begin
                cnt_tab[idx_reg] <= alu.new_count;
            end
            if (per_we) begin
                per_tab[idx_reg] <= per_wdata;
            end
            if (hdl_we) begin
                hdl_tab[idx_reg] <= handle_reg;
            end
        end
    end

    stsch_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_periodic_task_slot_scheduler.sv */
// Self-checking testbench of the periodic task slot scheduler: directed and random traffic.
`timescale 1ns / 1ps

module tb_periodic_task_slot_scheduler;
    import stsch_pkg::*;

    // One command or tick waiting to be sent to the block.
    typedef struct {
        logic [FUNC_W-1:0] op;
        word_t             elapsed;
        word_t             handle;
        word_t             period;
        bit                drain;
    } sched_cmd_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // elapsed_ticks, task_handle, period
    logic [FUNC_W-1:0] s_tuser = FUNC_TICK;  // func
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // fired_handle, slot_index, status, zero fill
    logic m_tuser;  // fired
    logic m_tlast;

    // Mirror of the slot table, stepped on every accepted input transfer.
    word_t tbl_handle [NUM_SLOTS];
    word_t tbl_period [NUM_SLOTS];
    word_t tbl_count  [NUM_SLOTS];

    sched_cmd_t cmd_backlog[$];
    result_t    due_reports[$];
    word_t      known_ids[$];
    int         cmds_sent = 0;
    int         cmds_taken = 0;
    int         errors = 0;
    int         in_gap = 0;
    int         rdy_gap = 0;
    bit         quiet_tail = 1'b0;

    periodic_task_slot_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock and reset.
    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Print one mismatch line and count it.
    task automatic flag_mismatch(input string what);
        if (errors < 100) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        errors++;
    endtask

    task automatic add_cmd(input logic [FUNC_W-1:0] op, input word_t elapsed,
                           input word_t handle, input word_t period, input bit drain);
        sched_cmd_t c;
        c.op = op;
        c.elapsed = elapsed;
        c.handle = handle;
        c.period = period;
        c.drain = drain;
        cmd_backlog.push_back(c);
    endtask

    // Apply one input item to the slot table mirror and queue the reports it causes.
    task automatic advance_slot_table(input logic [FUNC_W-1:0] op, input word_t elapsed,
                                      input word_t handle, input word_t period);
        result_t    r;
        logic [16:0] sum;
        int         hit;
        int         first_fire;
        first_fire = due_reports.size();
        hit = -1;
        r = '0;
        if (op == FUNC_TICK) begin
            if (elapsed == 0) return;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tbl_period[i] != 0) begin
                    sum = {1'b0, tbl_count[i]} + {1'b0, elapsed};
                    if (sum > 17'h0FFFF) sum = 17'h0FFFF;
                    if (sum > {1'b0, tbl_period[i]}) begin
                        sum = sum - {1'b0, tbl_period[i]};
                        r.fired = 1'b1;
                        r.handle = tbl_handle[i];
                        r.slot_index = SLOT_W'(i);
                        r.status = STAT_OK;
                        r.last = 1'b0;
                        due_reports.push_back(r);
                    end
                    tbl_count[i] = sum[WORD_W-1:0];
                end
            end
            // The final fired slot of the tick carries the last marker.
            if (due_reports.size() > first_fire) begin
                due_reports[due_reports.size()-1].last = 1'b1;
            end
            return;
        end
        r.fired = 1'b0;
        r.last = 1'b1;
        r.handle = handle;
        r.slot_index = '0;
        if (op == FUNC_REG) begin
            if (handle == 0) begin
                r.status = STAT_NOTFOUND;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (hit < 0 && tbl_handle[i] == 0) hit = i;
                end
                if (hit < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_handle[hit] = handle;
                    tbl_period[hit] = period;
                    r.slot_index = SLOT_W'(hit);
                    r.status = STAT_OK;
                end
            end
        end else begin
            // Stop and start act on the lowest slot holding the handle.
            if (handle != 0) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (hit < 0 && tbl_handle[i] == handle) hit = i;
                end
            end
            if (hit < 0) begin
                r.status = STAT_NOTFOUND;
            end else begin
                tbl_period[hit] = (op == FUNC_STOP) ? word_t'(0) : period;
                r.handle = tbl_handle[hit];
                r.slot_index = SLOT_W'(hit);
                r.status = STAT_OK;
            end
        end
        due_reports.push_back(r);
    endtask

    // Input side: present items from the backlog with random gaps.
    always @(negedge aclk) begin : drive_inputs
        logic       vld_next;
        sched_cmd_t c;
        vld_next = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && cmds_taken == cmds_sent) vld_next = 1'b0;
            if (!vld_next) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (cmd_backlog.size() > 0) begin
                    if (cmd_backlog[0].drain && due_reports.size() > 0) begin
                        // Hold off until every outstanding report has arrived.
                    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                        in_gap = $urandom_range(0, 5);
                    end else begin
                        c = cmd_backlog.pop_front();
                        s_tdata <= {c.period, c.handle, c.elapsed};
                        s_tuser <= c.op;
                        vld_next = 1'b1;
                        cmds_sent++;
                        if (cmd_backlog.size() < 40) quiet_tail = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= vld_next;
    end

    // Result side: stall the receiver in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rdy_gap > 0) begin
            rdy_gap--;
            m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rdy_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Step the mirror on each input transfer and check each result transfer.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                advance_slot_table(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
                cmds_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    flag_mismatch($sformatf("result with none pending: handle %h slot %0d",
                                            m_tdata[15:0], m_tdata[18:16]));
                end else begin
                    want = due_reports.pop_front();
                    if (m_tuser !== want.fired || m_tdata[15:0] !== want.handle ||
                        m_tdata[18:16] !== want.slot_index || m_tdata[20:19] !== want.status ||
                        m_tlast !== want.last) begin
                        flag_mismatch($sformatf({"got fired %b handle %h slot %0d status %0d ",
                                                 "last %b, want %b %h %0d %0d %b"},
                                                m_tuser, m_tdata[15:0], m_tdata[18:16],
                                                m_tdata[20:19], m_tlast, want.fired,
                                                want.handle, want.slot_index, want.status,
                                                want.last));
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        word_t h;
        word_t p;
        word_t e;
        int    pick;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_handle[i] = '0;
            tbl_period[i] = '0;
            tbl_count[i] = '0;
        end

        // Empty table: zero tick, unknown handle, zero handles.
        add_cmd(FUNC_TICK, 16'd0, 16'd0, 16'd0, 1'b0);
        add_cmd(FUNC_STOP, 16'd0, 16'd5, 16'd0, 1'b0);
        add_cmd(FUNC_START, 16'd0, 16'd0, 16'd7, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'd0, 16'd3, 1'b0);
        // Fill the table, with a duplicate handle and a stopped task.
        add_cmd(FUNC_REG, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        add_cmd(FUNC_REG, 16'hFFFF, 16'd1, 16'd0, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'h8000, 16'd1, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'd2, 16'd3, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'd2, 16'd5, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'h5A5A, 16'd2, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'hA5A5, 16'h8000, 1'b0);
        add_cmd(FUNC_REG, 16'd0, 16'h7FFF, 16'd10, 1'b0);
        // Table full.
        add_cmd(FUNC_REG, 16'd0, 16'd9, 16'd4, 1'b1);
        // Saturating tick fires almost every slot at once.
        add_cmd(FUNC_TICK, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        add_cmd(FUNC_TICK, 16'd0, 16'd0, 16'd0, 1'b0);
        add_cmd(FUNC_TICK, 16'd1, 16'd0, 16'd0, 1'b0);
        add_cmd(FUNC_STOP, 16'd0, 16'd2, 16'd0, 1'b0);
        add_cmd(FUNC_START, 16'd0, 16'd2, 16'h7FFF, 1'b0);
        add_cmd(FUNC_START, 16'd0, 16'd1, 16'd4, 1'b0);
        add_cmd(FUNC_STOP, 16'd0, 16'hFFFF, 16'd0, 1'b1);
        add_cmd(FUNC_START, 16'd0, 16'h1234, 16'd6, 1'b0);
        add_cmd(FUNC_STOP, 16'd0, 16'd0, 16'd0, 1'b0);
        add_cmd(FUNC_TICK, 16'd5, 16'd0, 16'd0, 1'b0);
        known_ids = '{16'hFFFF, 16'd1, 16'h8000, 16'd2, 16'h5A5A, 16'hA5A5, 16'h7FFF};

        // Random traffic: mostly ticks and re-periods on registered tasks.
        for (int n = 0; n < 250; n++) begin
            pick = $urandom_range(0, 99);
            h = known_ids[$urandom_range(0, known_ids.size() - 1)];
            case ($urandom_range(0, 6))
                0: p = 16'd0;
                1: p = word_t'($urandom);
                default: p = word_t'($urandom_range(1, 30));
            endcase
            case ($urandom_range(0, 9))
                0: e = 16'd0;
                1, 2: e = word_t'($urandom);
                default: e = word_t'($urandom_range(1, 20));
            endcase
            if (pick < 45) begin
                add_cmd(FUNC_TICK, e, word_t'($urandom), p, (n % 60) == 59);
            end else if (pick < 75) begin
                add_cmd(FUNC_START, e, h, p, 1'b0);
            end else if (pick < 83) begin
                add_cmd(FUNC_STOP, e, h, p, 1'b0);
            end else if (pick < 90) begin
                add_cmd(FUNC_REG, e, word_t'($urandom), p, 1'b0);
            end else if (pick < 93) begin
                add_cmd(FUNC_W'($urandom_range(1, 3)), e, 16'd0, p, 1'b0);
            end else begin
                add_cmd(FUNC_W'($urandom_range(2, 3)), e, word_t'($urandom), p, 1'b0);
            end
        end

        wait (cmd_backlog.size() == 0 && cmds_taken == cmds_sent);
        wait (due_reports.size() == 0);
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
